// File: rtl/line_rasterizer_assert.svh
// assertion macros used by the checker file
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lr_pkg.sv
`timescale 1ns / 1ps

package lr_pkg;

  localparam int GRID_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int ERR_W     = COORD_W + 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ERR_W-1:0]   err_t;

  localparam coord_t GRID_MAX = coord_t'(GRID_SIZE - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lr_state_e;

  typedef struct packed {
    logic y_down;
    logic x_down;
    logic x_major;
  } step_flags_t;

  typedef struct packed {
    logic load;
    logic step;
  } lr_cmd_t;

  typedef struct packed {
    logic last;
  } lr_status_t;

  function automatic coord_t clamp_coord(coord_t v);
    return (v > GRID_MAX) ? GRID_MAX : v;
  endfunction

  function automatic coord_t step_coord(coord_t v, logic down);
    return down ? coord_t'(v - 1'b1) : coord_t'(v + 1'b1);
  endfunction

endpackage

// File: rtl/lr_ctrl.sv
`timescale 1ns / 1ps

module lr_ctrl import lr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  input  lr_status_t status_i,
  output lr_cmd_t    cmd_o
);

  lr_state_e state_q, state_d;
  logic      done;

  // final pixel of the current line leaves in this cycle
  assign done = (state_q == ST_RUN) && m_ready_i && status_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (done && !s_valid_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
      end
      ST_RUN: begin
        m_valid_o = 1'b1;
        s_ready_o = done;
        cmd_o.step = m_ready_i && !status_i.last;
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
    cmd_o.load = s_valid_i && s_ready_o;
  end

endmodule

// File: rtl/lr_datapath.sv
`timescale 1ns / 1ps

module lr_datapath import lr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lr_cmd_t    cmd_i,
  input  coord_t     x_start_i,
  input  coord_t     y_start_i,
  input  coord_t     x_end_i,
  input  coord_t     y_end_i,
  output coord_t     pixel_x_o,
  output coord_t     pixel_y_o,
  output lr_status_t status_o
);

  coord_t      cur_x_q, cur_x_d;
  coord_t      cur_y_q, cur_y_d;
  err_t        err_q, err_d;
  coord_t      rem_q, rem_d;
  coord_t      minor_q, minor_d;
  coord_t      major_q, major_d;
  step_flags_t flags_q, flags_d;

  coord_t      x0, y0, x1, y1, dx, dy;
  step_flags_t flags_new;
  logic        minor_step;
  err_t        minor2, major2;

  always_comb begin
    x0 = clamp_coord(x_start_i);
    y0 = clamp_coord(y_start_i);
    x1 = clamp_coord(x_end_i);
    y1 = clamp_coord(y_end_i);
    dx = (x1 >= x0) ? coord_t'(x1 - x0) : coord_t'(x0 - x1);
    dy = (y1 >= y0) ? coord_t'(y1 - y0) : coord_t'(y0 - y1);
    flags_new.x_major = dx > dy;
    flags_new.x_down  = x1 < x0;
    flags_new.y_down  = y1 < y0;
  end

  assign minor2     = err_t'({minor_q, 1'b0});
  assign major2     = err_t'({major_q, 1'b0});
  // error not negative: the minor axis steps too
  assign minor_step = !err_q[ERR_W-1];

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    err_d   = err_q;
    rem_d   = rem_q;
    minor_d = minor_q;
    major_d = major_q;
    flags_d = flags_q;
    if (cmd_i.load) begin
      flags_d = flags_new;
      major_d = flags_new.x_major ? dx : dy;
      minor_d = flags_new.x_major ? dy : dx;
      rem_d   = major_d;
      err_d   = err_t'(err_t'({minor_d, 1'b0}) - err_t'(major_d));
      cur_x_d = x0;
      cur_y_d = y0;
    end else if (cmd_i.step) begin
      if (flags_q.x_major || minor_step) cur_x_d = step_coord(cur_x_q, flags_q.x_down);
      if (!flags_q.x_major || minor_step) cur_y_d = step_coord(cur_y_q, flags_q.y_down);
      err_d = minor_step ? err_t'(err_q + minor2 - major2) : err_t'(err_q + minor2);
      rem_d = coord_t'(rem_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      err_q   <= '0;
      rem_q   <= '0;
      minor_q <= '0;
      major_q <= '0;
      flags_q <= '0;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      err_q   <= err_d;
      rem_q   <= rem_d;
      minor_q <= minor_d;
      major_q <= major_d;
      flags_q <= flags_d;
    end
  end

  assign pixel_x_o     = cur_x_q;
  assign pixel_y_o     = cur_y_q;
  assign status_o.last = (rem_q == '0);

endmodule

// File: rtl/line_rasterizer.sv
`timescale 1ns / 1ps
// line rasterizer: integer Bresenham over a 64 by 64 grid, all octants
// slave channel takes one line request: start and end coordinates
// master channel gives the pixels of that line in order, start and end
// included, with tlast high on the final pixel
// the first pixel is shown in the cycle after the request is accepted
// throughput: one pixel per cycle while the master side is ready; a line has N pixels
// (N = 1 + the larger of |dx| and |dy|, at most 64); the next request is accepted
// in the cycle the final pixel is taken, set by the single stepping register
// set in the datapath that walks one pixel per cycle
// tready on the slave side stays low while a line is being emitted, until its final pixel is taken
// a stall on the master side holds the shown pixel and freezes the walk
// reset: asynchronous, active low; the block comes up idle, ready for a
// request, with no pixel pending
// coordinates above the grid edge are saturated to the last row or column

module line_rasterizer import lr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_start [5:0], y_start [11:6], x_end [17:12], y_end [23:18]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x [5:0], pixel_y [11:6], zero fill [15:12]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  lr_cmd_t    cmd;
  lr_status_t status;
  coord_t     pixel_x, pixel_y;

  lr_ctrl u_lr_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lr_datapath u_lr_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .x_start_i (s_axis_tdata[5:0]),
    .y_start_i (s_axis_tdata[11:6]),
    .x_end_i   (s_axis_tdata[17:12]),
    .y_end_i   (s_axis_tdata[23:18]),
    .pixel_x_o (pixel_x),
    .pixel_y_o (pixel_y),
    .status_o  (status)
  );

  assign m_axis_tdata = {4'b0000, pixel_y, pixel_x};
  assign m_axis_tlast = status.last;

endmodule

// File: rtl/lr_checker.sv
`timescale 1ns / 1ps
`include "line_rasterizer_assert.svh"

module lr_checker import lr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic   s_acc;
  coord_t end_x_q, end_y_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // endpoint of the request in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_x_q <= '0;
      end_y_q <= '0;
    end else if (s_acc) begin
      end_x_q <= clamp_coord(s_axis_tdata[17:12]);
      end_y_q <= clamp_coord(s_axis_tdata[23:18]);
    end
  end

  `LR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled pixel changed")

  `LR_ASSERT_NEXT(a_first_pixel, clk_i, rst_ni, s_acc, m_axis_tvalid && (m_axis_tdata[5:0] == clamp_coord($past(s_axis_tdata[5:0]))) && (m_axis_tdata[11:6] == clamp_coord($past(s_axis_tdata[11:6]))), "first pixel is not the start point")

  `LR_ASSERT_IMPL(a_last_pixel, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, (m_axis_tdata[5:0] == end_x_q) && (m_axis_tdata[11:6] == end_y_q), "last pixel is not the end point")

  `LR_ASSERT_IMPL(a_busy_no_req, clk_i, rst_ni, m_axis_tvalid && !(m_axis_tready && m_axis_tlast), !s_axis_tready, "request taken in the middle of a line")

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);

// File: test/tb_line_rasterizer.sv
`timescale 1ns / 1ps

module tb_line_rasterizer;
  import lr_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  typedef enum int {
    RX_FREE,
    RX_HALF,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  localparam int N_RANDOM   = 208;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 70;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic [23:0] line_q[$];
  pixel_t      pixel_q[$];
  int          lines_total;
  int          lines_drawn;
  int          pixels_checked;
  int          longest_line;
  int          err_count;
  logic        req_taken = 1'b0;

  int          burst_left = 1;
  int          gap_left = 0;
  int          rx_cycle = 0;
  int          hold_left = 0;
  rx_mode_e    rx_mode = RX_FREE;

  line_rasterizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // walks one line the Bresenham way and queues every pixel it should produce
  function automatic void plot_line(input coord_t xa, input coord_t ya,
                                    input coord_t xb, input coord_t yb);
    coord_t cx, cy, ex, ey;
    int     dx, dy, maj, mnr, err;
    logic   x_major, x_down, y_down;
    pixel_t p;
    cx = (xa > GRID_MAX) ? GRID_MAX : xa;
    cy = (ya > GRID_MAX) ? GRID_MAX : ya;
    ex = (xb > GRID_MAX) ? GRID_MAX : xb;
    ey = (yb > GRID_MAX) ? GRID_MAX : yb;
    dx = (ex >= cx) ? int'(ex) - int'(cx) : int'(cx) - int'(ex);
    dy = (ey >= cy) ? int'(ey) - int'(cy) : int'(cy) - int'(ey);
    // a tie makes y the major axis
    x_major = dx > dy;
    x_down  = ex < cx;
    y_down  = ey < cy;
    maj = x_major ? dx : dy;
    mnr = x_major ? dy : dx;
    err = 2 * mnr - maj;
    if (maj + 1 > longest_line) longest_line = maj + 1;
    for (int i = 0; i <= maj; i++) begin
      p.x    = cx;
      p.y    = cy;
      p.last = (i == maj);
      pixel_q.push_back(p);
      if (i < maj) begin
        if (x_major) cx = x_down ? cx - 1'b1 : cx + 1'b1;
        else cy = y_down ? cy - 1'b1 : cy + 1'b1;
        if (err >= 0) begin
          if (x_major) cy = y_down ? cy - 1'b1 : cy + 1'b1;
          else cx = x_down ? cx - 1'b1 : cx + 1'b1;
          err += 2 * (mnr - maj);
        end else begin
          err += 2 * mnr;
        end
      end
    end
  endfunction

  function automatic coord_t near_coord(input coord_t c);
    int t;
    t = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (t < 0) t = 0;
    if (t > GRID_SIZE - 1) t = GRID_SIZE - 1;
    return coord_t'(t);
  endfunction

  task automatic add_line(input coord_t xa, input coord_t ya,
                          input coord_t xb, input coord_t yb);
    line_q.push_back({yb, xb, ya, xa});
    lines_total++;
  endtask

  // sender: bursts of requests separated by random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (req_taken || !s_axis_tvalid)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (line_q.size() > 0) begin
        s_axis_tdata  <= line_q.pop_front();
        s_axis_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern is drawn anew at regular intervals, with two long holds
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle == 1500 || rx_cycle == 8000) hold_left = HOLD_LEN;
      if (rx_cycle % 250 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:     m_axis_tready <= 1'b1;
          RX_HALF:     m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:     m_axis_tready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  // monitor: predicts on each accepted request, checks each accepted pixel
  always @(posedge clk_i) begin
    pixel_t want;
    pixel_t got;
    req_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        plot_line(s_axis_tdata[5:0], s_axis_tdata[11:6],
                  s_axis_tdata[17:12], s_axis_tdata[23:18]);
        lines_drawn++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x    = m_axis_tdata[5:0];
        got.y    = m_axis_tdata[11:6];
        got.last = m_axis_tlast;
        if (pixel_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                   got.x, got.y, got.last);
        end else begin
          want = pixel_q.pop_front();
          pixels_checked++;
          if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
            err_count++;
            $display("%0t: pixel mismatch, expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $time, want.x, want.y, want.last, got.x, got.y, got.last);
          end
        end
      end
    end
  end

  initial begin
    coord_t xa, ya, xb, yb;
    int     pick;
    // single points at both corners
    add_line(0, 0, 0, 0);
    add_line(63, 63, 63, 63);
    // full-length horizontal and vertical lines both ways
    add_line(0, 0, 63, 0);
    add_line(63, 0, 0, 0);
    add_line(0, 0, 0, 63);
    add_line(0, 63, 0, 0);
    // full diagonals, where the tie makes y major
    add_line(0, 0, 63, 63);
    add_line(63, 63, 0, 0);
    add_line(0, 63, 63, 0);
    add_line(63, 0, 0, 63);
    // one line in each octant
    add_line(10, 10, 40, 20);
    add_line(10, 10, 20, 40);
    add_line(40, 20, 10, 10);
    add_line(20, 40, 10, 10);
    add_line(10, 20, 40, 10);
    add_line(40, 10, 10, 20);
    add_line(20, 10, 10, 40);
    add_line(10, 40, 20, 10);
    // two-pixel lines and nearly flat or steep ones
    add_line(5, 5, 6, 6);
    add_line(5, 5, 6, 5);
    add_line(0, 0, 63, 1);
    add_line(1, 0, 0, 63);

    for (int n = 0; n < N_RANDOM; n++) begin
      xa   = coord_t'($urandom_range(0, 63));
      ya   = coord_t'($urandom_range(0, 63));
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        xb = coord_t'($urandom_range(0, 63));
        yb = coord_t'($urandom_range(0, 63));
      end else if (pick < 9) begin
        xb = near_coord(xa);
        yb = near_coord(ya);
      end else begin
        // axis-aligned or diagonal through the start point
        case ($urandom_range(0, 2))
          0: begin xb = coord_t'($urandom_range(0, 63)); yb = ya; end
          1: begin xb = xa; yb = coord_t'($urandom_range(0, 63)); end
          default: begin
            xb = coord_t'($urandom_range(0, 63));
            yb = coord_t'(int'(ya) + int'(xb) - int'(xa));
            if (int'(ya) + int'(xb) - int'(xa) < 0 ||
                int'(ya) + int'(xb) - int'(xa) > 63) yb = ya;
          end
        endcase
      end
      add_line(xa, ya, xb, yb);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (lines_drawn < lines_total || pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d lines (%0d directed, rest random) and %0d pixels, longest %0d",
             lines_drawn, lines_total - N_RANDOM, pixels_checked, longest_line);
    $display("receiver ran %0d cycles with varying stalls and two long holds", rx_cycle);
    if (err_count == 0) begin
      $display("tb_line_rasterizer: done, clean");
    end else begin
      $display("tb_line_rasterizer: done, errors");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d pixels still expected", pixel_q.size());
    $display("tb_line_rasterizer: done, errors");
    $finish;
  end

endmodule
